// ===== rtl/core/galois_lfsr16_ranged_rng_top_assert.svh =====
// assertion macros for the ranged lfsr random source
`ifndef GALOIS_LFSR16_RANGED_RNG_TOP_ASSERT_SVH
`define GALOIS_LFSR16_RANGED_RNG_TOP_ASSERT_SVH

// next-cycle implication, masked while reset is asserted
`define GLFSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("glfsr check failed");

// same-cycle implication, masked while reset is asserted
`define GLFSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("glfsr check failed");

// next-cycle implication that also runs through reset
`define GLFSR_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("glfsr check failed");

`endif

// ===== rtl/core/glfsr_pkg.sv =====
// shared types, constants and lfsr step function for the ranged random source
`timescale 1ns / 1ps

package glfsr_pkg;

    localparam int DATA_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DATA_W-1:0] TAPS_RIGHT = 16'hB400;
    localparam logic [DATA_W-1:0] TAPS_LEFT  = 16'h002D;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR  = 2'd1;

    localparam logic DIR_RIGHT = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] diff;
        logic [DATA_W-1:0] lo;
        logic              err;
    } t_job;

    function automatic logic [DATA_W-1:0] lfsr_next(input logic [DATA_W-1:0] v,
                                                    input logic dir);
        logic [DATA_W-1:0] nv;
        if (dir == DIR_RIGHT) begin
            nv = {1'b0, v[DATA_W-1:1]} ^ (v[0] ? TAPS_RIGHT : '0);
        end else begin
            nv = {v[DATA_W-2:0], 1'b0} ^ (v[DATA_W-1] ? TAPS_LEFT : '0);
        end
        return nv;
    endfunction

endpackage

// ===== rtl/core/glfsr_front.sv =====
// front end: config registers, lfsr advance and bound classification per item
`timescale 1ns / 1ps

module glfsr_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [glfsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [glfsr_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic                               i_push,
    input  logic                               i_q_full,
    input  logic [glfsr_pkg::DATA_W-1:0]       i_range_min,
    input  logic [glfsr_pkg::DATA_W-1:0]       i_range_max,
    output logic                               o_job_push,
    output glfsr_pkg::t_job                    o_job
);
    import glfsr_pkg::*;

    logic [DATA_W-1:0] r_shift;
    logic [DATA_W-1:0] n_shift;
    logic              r_dir;
    logic              n_dir;
    logic [DATA_W-1:0] w_next;
    logic [DATA_W-1:0] w_diff;
    logic              w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign o_job_push  = i_push && !i_q_full;
    assign w_next      = lfsr_next(r_shift, r_dir);
    assign w_diff      = (i_range_max >= i_range_min) ? (i_range_max - i_range_min)
                                                      : (i_range_min - i_range_max);

    always_comb begin
        o_job.raw  = w_next;
        o_job.diff = w_diff;
        o_job.lo   = i_range_min;
        o_job.err  = (w_diff == '0);
    end

    always_comb begin
        n_shift = r_shift;
        n_dir   = r_dir;
        if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_SEED: n_shift = i_cfg_data;
                CFG_DIR:  n_dir   = i_cfg_data[0];
                default:  ;
            endcase
        end else if (o_job_push) begin
            n_shift = w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_dir   <= DIR_RIGHT;
        end else begin
            r_shift <= n_shift;
            r_dir   <= n_dir;
        end
    end

endmodule

// ===== rtl/core/glfsr_queue.sv =====
// short job queue between the front end and the divider
`timescale 1ns / 1ps

module glfsr_queue #(
    parameter int DEPTH = glfsr_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  glfsr_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output glfsr_pkg::t_job o_job,
    output logic            o_empty
);
    import glfsr_pkg::*;

    // depth of two or more
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/glfsr_back.sv =====
// back end: bit-serial restoring remainder, range offset and result register
`timescale 1ns / 1ps

module glfsr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  glfsr_pkg::t_job               i_job,
    output logic                          o_q_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [glfsr_pkg::DATA_W-1:0]  o_raw_value,
    output logic [glfsr_pkg::DATA_W-1:0]  o_ranged_value,
    output logic                          o_range_error
);
    import glfsr_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DATA_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvd, n_dvd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_raw, n_raw;
    logic [DATA_W-1:0] r_ranged, n_ranged;
    logic              r_err, n_err;

    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_rem_sub;
    logic              w_ge;
    logic              w_out_free;
    logic              w_load;

    assign w_rem_sh   = {r_rem, r_dvd[DATA_W-1]};
    assign w_rem_sub  = w_rem_sh - {1'b0, r_job.diff};
    assign w_ge       = (w_rem_sh >= {1'b0, r_job.diff});
    assign w_out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_raw       = r_raw;
        n_ranged    = r_ranged;
        n_err       = r_err;
        w_load      = 1'b0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                w_load = !i_q_empty;
            end
            S_DIV: begin
                n_rem = w_ge ? w_rem_sub[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
                n_dvd = {r_dvd[DATA_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_raw       = r_job.raw;
                    n_ranged    = r_rem + r_job.lo;
                    n_err       = r_job.err;
                    n_state     = S_IDLE;
                    w_load      = !i_q_empty;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // equal bounds skip the divider with a zero remainder
        if (w_load) begin
            n_job   = i_job;
            n_rem   = '0;
            n_dvd   = i_job.raw;
            n_cnt   = '0;
            n_state = i_job.err ? S_DONE : S_DIV;
        end
    end

    assign o_q_pop        = w_load;
    assign o_empty        = !r_out_valid;
    assign o_raw_value    = r_raw;
    assign o_ranged_value = r_ranged;
    assign o_range_error  = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_job       <= n_job;
            r_rem       <= n_rem;
            r_dvd       <= n_dvd;
            r_cnt       <= n_cnt;
            r_raw       <= n_raw;
            r_ranged    <= n_ranged;
            r_err       <= n_err;
        end
    end

endmodule

// ===== rtl/core/galois_lfsr16_ranged_rng_top.sv =====
// equal bounds bypass the divider and go straight to the result register
// the 16-step bit-serial remainder unit takes one item at a time, and the next only as it hands a result on
// the front end takes items back to back until the job queue fills
// reset: synchronous active low, clears shift register (seed), direction, job queue and result flag
// top level of the ranged lfsr random source
`timescale 1ns / 1ps

module galois_lfsr16_ranged_rng_top #(
    parameter int QUEUE_DEPTH = glfsr_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [glfsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [glfsr_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [glfsr_pkg::DATA_W-1:0]     i_range_min,
    input  logic [glfsr_pkg::DATA_W-1:0]     i_range_max,
    output logic                             empty,
    input  logic                             pop,
    output logic [glfsr_pkg::DATA_W-1:0]     o_raw_value,
    output logic [glfsr_pkg::DATA_W-1:0]     o_ranged_value,
    output logic                             o_range_error
);
    import glfsr_pkg::*;

    t_job w_front_job;
    t_job w_back_job;
    logic w_job_push;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;

    assign full = w_q_full;

    glfsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_q_full    (w_q_full),
        .i_range_min (i_range_min),
        .i_range_max (i_range_max),
        .o_job_push  (w_job_push),
        .o_job       (w_front_job)
    );

    glfsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_job   (w_back_job),
        .o_empty (w_q_empty)
    );

    glfsr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_job          (w_back_job),
        .o_q_pop        (w_q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_raw_value    (o_raw_value),
        .o_ranged_value (o_ranged_value),
        .o_range_error  (o_range_error)
    );

`include "galois_lfsr16_ranged_rng_top_assert.svh"

    `GLFSR_ASSERT_NEXT(a_push_fills_queue, w_job_push, !w_q_empty)
    `GLFSR_ASSERT_NOW(a_queue_flags_exclusive, w_q_full, !w_q_empty)
    `GLFSR_ASSERT_NEXT(a_no_pop_when_empty, w_q_empty && !w_job_push, !w_q_full)
    `GLFSR_ASSERT_NEXT_ALWAYS(a_reset_clears_result, !i_rst_n, empty)

endmodule

// ===== sim/tb_galois_lfsr16_ranged_rng_top.sv =====
// testbench for the ranged lfsr random source: predicts every result and checks it
`timescale 1ns / 1ps

module tb_galois_lfsr16_ranged_rng_top;
    import glfsr_pkg::*;

    localparam int  CYCLE_LIMIT = 600000;
    localparam int  SETTLE_CYCLES = 25;
    localparam logic DIR_LEFT = ~DIR_RIGHT;

    typedef struct {
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] ranged;
        logic              err;
    } rng_result_t;

    // tracks the shift register and direction, holds the results still to come
    class rng_scoreboard;
        logic [DATA_W-1:0] shift_reg;
        logic              direction;
        rng_result_t       pending_results[$];
        int unsigned       mismatches;
        int unsigned       checked;

        function new();
            shift_reg   = '0;
            direction   = DIR_RIGHT;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            if (idx == CFG_SEED) begin
                shift_reg = data;
            end else if (idx == CFG_DIR) begin
                direction = data[0];
            end
        endfunction

        function void note_request(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
            logic              out_bit;
            logic [DATA_W-1:0] span;
            rng_result_t       res;
            if (direction == DIR_RIGHT) begin
                out_bit   = shift_reg[0];
                shift_reg = shift_reg >> 1;
                if (out_bit) shift_reg = shift_reg ^ TAPS_RIGHT;
            end else begin
                out_bit   = shift_reg[DATA_W-1];
                shift_reg = shift_reg << 1;
                if (out_bit) shift_reg = shift_reg ^ TAPS_LEFT;
            end
            span    = (hi >= lo) ? hi - lo : lo - hi;
            res.raw = shift_reg;
            if (span == '0) begin
                res.ranged = lo;
                res.err    = 1'b1;
            end else begin
                // sum wraps to 16 bits
                res.ranged = (shift_reg % span) + lo;
                res.err    = 1'b0;
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [DATA_W-1:0] raw, logic [DATA_W-1:0] ranged,
                                   logic err);
            rng_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result raw %h ranged %h err %b",
                         $time, raw, ranged, err);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (raw !== want.raw) begin
                $display("%0t: raw_value expected %h actual %h", $time, want.raw, raw);
                mismatches++;
            end
            if (ranged !== want.ranged) begin
                $display("%0t: ranged_value expected %h actual %h",
                         $time, want.ranged, ranged);
                mismatches++;
            end
            if (err !== want.err) begin
                $display("%0t: range_error expected %b actual %b", $time, want.err, err);
                mismatches++;
            end
        endfunction

        function int waiting();
            return pending_results.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [DATA_W-1:0]    i_range_min = '0;
    logic [DATA_W-1:0]    i_range_max = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [DATA_W-1:0]    o_raw_value;
    logic [DATA_W-1:0]    o_ranged_value;
    logic                 o_range_error;

    rng_scoreboard sb = new();
    logic          calm = 1'b0;
    int unsigned   cycles = 0;
    int unsigned   sent = 0;
    int unsigned   cfg_writes = 0;
    int            pop_hold = 0;

    galois_lfsr16_ranged_rng_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_range_min    (i_range_min),
        .i_range_max    (i_range_max),
        .empty          (empty),
        .pop            (pop),
        .o_raw_value    (o_raw_value),
        .o_ranged_value (o_ranged_value),
        .o_range_error  (o_range_error)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, sb.waiting());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stalls, now and then a long one; none while calm is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (calm) begin
            pop <= 1'b1;
        end else if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else if ($urandom_range(199) == 0) begin
            pop      <= 1'b0;
            pop_hold = $urandom_range(60, 20);
        end else begin
            pop <= ($urandom_range(99) >= 25);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_raw_value, o_ranged_value, o_range_error);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 25) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_range_min <= lo;
        i_range_max <= hi;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(lo, hi);
        sent++;
    endtask

    // stop pushing and wait until every result is back
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        lo = DATA_W'($urandom_range(65535));
        hi = DATA_W'($urandom_range(65535));
        case ($urandom_range(9))
            0: hi = lo;
            1, 2: hi = lo + DATA_W'($urandom_range(16, 1));
            3: lo = hi + DATA_W'($urandom_range(16, 1));
            4: begin
                lo = $urandom_range(1) ? '0 : '1;
                hi = $urandom_range(1) ? '0 : DATA_W'($urandom_range(65535));
            end
            default: ;
        endcase
        send_request(lo, hi);
    endtask

    initial begin
        int unsigned       phase_items;
        logic [DATA_W-1:0] phase_seed;
        logic              phase_dir;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register still zero after reset: locked in both directions
        send_request(16'h0000, 16'h0000);
        send_request(16'h0000, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000);
        drain();
        write_reg(CFG_DIR, DATA_W'(DIR_LEFT));
        send_request(16'h1234, 16'h4321);
        drain();

        write_reg(CFG_DIR, DATA_W'(DIR_RIGHT));
        write_reg(CFG_SEED, 16'hACE1);
        send_request(16'h0000, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000);
        send_request(16'h0000, 16'h0001);
        send_request(16'h0001, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'h0000, 16'h0000);
        send_request(16'd100, 16'd200);
        send_request(16'd200, 16'd100);
        send_request(16'hFFFE, 16'hFFFF);
        send_request(16'h8000, 16'h7FFF);
        send_request(16'h5555, 16'hAAAA);
        drain();

        // direction flip keeps the register contents
        write_reg(CFG_DIR, DATA_W'(DIR_LEFT));
        send_request(16'h0000, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000);
        send_request(16'd12, 16'd12);
        send_request(16'd1000, 16'd1017);
        send_request(16'hFFF0, 16'h0010);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: phase_seed = 16'h0001;
                1: phase_seed = 16'hFFFF;
                2: phase_seed = 16'h8000;
                6: phase_seed = 16'h0000;
                default: phase_seed = DATA_W'($urandom_range(65535, 1));
            endcase
            phase_items = (phase == 6) ? 30 : 240;
            phase_dir   = (phase % 2 == 0) ? DIR_RIGHT : DIR_LEFT;
            calm        = (phase == 2);
            write_reg(CFG_SEED, phase_seed);
            write_reg(CFG_DIR, DATA_W'(phase_dir));
            for (int n = 0; n < phase_items; n++) begin
                if (n == phase_items / 2) begin
                    drain();
                    write_reg(CFG_DIR, DATA_W'(~phase_dir));
                end
                send_random_request();
            end
            drain();
        end
        calm = 1'b0;

        @(negedge i_clk);
        push <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests and %0d register writes over 8 seeded phases",
                 sent, cfg_writes);
        $display("%0d results checked, %0d mismatches, %0d results never seen",
                 sb.checked, sb.mismatches, sb.waiting());
        if (sb.mismatches == 0 && sb.waiting() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
